### design/fcbm_pkg.sv
// shared codes and constants of the block-link table manager
package fcbm_pkg;

  localparam int BLOCK_W = 8;
  localparam int LINK_DEPTH = 256;
  localparam logic [8:0] WALK_LIMIT = 9'd256;
  localparam int MAX_OUT = 16;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [63:0] name_t;
  typedef logic [2:0] status_t;
  typedef logic [3:0] op_t;

  localparam op_t OP_FORMAT = 4'd0;
  localparam op_t OP_CREATE = 4'd1;
  localparam op_t OP_REMOVE = 4'd2;
  localparam op_t OP_FIRST  = 4'd3;
  localparam op_t OP_APPEND = 4'd4;
  localparam op_t OP_UNLINK = 4'd5;
  localparam op_t OP_CHECK  = 4'd6;
  localparam op_t OP_NEXT   = 4'd7;
  localparam op_t OP_LIST   = 4'd8;

  localparam status_t ST_OK           = 3'd0;
  localparam status_t ST_NOT_FOUND    = 3'd1;
  localparam status_t ST_EXISTS       = 3'd2;
  localparam status_t ST_DIR_FULL     = 3'd3;
  localparam status_t ST_NOT_EMPTY    = 3'd4;
  localparam status_t ST_NOT_IN_CHAIN = 3'd5;
  localparam status_t ST_DISK_FULL    = 3'd6;

  localparam logic CFG_BLOCK_COUNT = 1'b0;
  localparam logic CFG_FIRST_DATA  = 1'b1;

endpackage

### design/fat_chain_block_manager.sv
// fat block manager: root directory and block-link table with free list
// Commands enter on in_valid/in_stall (op, file_name, block_number); results
// leave on out_valid/out_stall (status, result_block, listed_name, last).
// Configuration: cfg_we writes cfg_data into block_count (index 0) or
// first_data_block (index 1); write only while the block is idle.
// One command is worked at a time; in_stall is high while one is in work.
// Name lookup visits the directory entries one at a time through the name
// ram before a named command's chain work. Chain walks for append, unlink,
// check and next read the link ram one block at a time, up to 256 steps.
// Format sweeps all 256 links, one a cycle.
// List gives one result per used entry (at most 16), or one not-found
// result if no entry is used; the last one is marked by last.
// A result sits in the output register until taken; a new command may be
// taken meanwhile, but the block waits to put out its next result until then.
// Reset (rst, synchronous) empties the directory and restores the registers;
// the link table holds nothing meaningful until the first format.
module fat_chain_block_manager #(
  parameter int ROOT_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  op,
  input  logic [63:0] file_name,
  input  logic [7:0]  block_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  result_block,
  output logic [63:0] listed_name,
  output logic        last
);

  localparam int EW = (ROOT_ENTRIES > 1) ? $clog2(ROOT_ENTRIES) : 1;
  localparam int CW = $clog2(ROOT_ENTRIES + 1);
  localparam int NDEPTH = (ROOT_ENTRIES > 1) ? ROOT_ENTRIES : 2;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_FMT  = 5'd1;
  localparam logic [4:0] S_SRD  = 5'd2;
  localparam logic [4:0] S_SCMP = 5'd3;
  localparam logic [4:0] S_DISP = 5'd4;
  localparam logic [4:0] S_AP0  = 5'd5;
  localparam logic [4:0] S_AP1  = 5'd6;
  localparam logic [4:0] S_AP2  = 5'd7;
  localparam logic [4:0] S_AP3  = 5'd8;
  localparam logic [4:0] S_AWI  = 5'd9;
  localparam logic [4:0] S_AWW  = 5'd10;
  localparam logic [4:0] S_AFIN = 5'd11;
  localparam logic [4:0] S_MWI  = 5'd12;
  localparam logic [4:0] S_MWW  = 5'd13;
  localparam logic [4:0] S_NX   = 5'd14;
  localparam logic [4:0] S_UL2  = 5'd15;
  localparam logic [4:0] S_UL3  = 5'd16;
  localparam logic [4:0] S_UL4  = 5'd17;
  localparam logic [4:0] S_UL5  = 5'd18;
  localparam logic [4:0] S_LST  = 5'd19;
  localparam logic [4:0] S_LRD  = 5'd20;
  localparam logic [4:0] S_LGOT = 5'd21;
  localparam logic [4:0] S_EMIT = 5'd22;

  logic [4:0] state;
  logic [8:0] block_count;
  logic [7:0] first_data_block;

  fcbm_pkg::op_t     op_q;
  fcbm_pkg::name_t   name_q;
  fcbm_pkg::block_t  blk_q;
  logic [CW-1:0]     idx_q;
  logic              found_q;
  logic [8:0]        steps;
  fcbm_pkg::block_t  b_q;
  fcbm_pkg::block_t  pred_q;
  fcbm_pkg::block_t  alloc_q;
  fcbm_pkg::block_t  tmp_q;

  logic [ROOT_ENTRIES-1:0] used_q;
  fcbm_pkg::block_t        first_q [ROOT_ENTRIES];

  fcbm_pkg::status_t res_status;
  fcbm_pkg::block_t  res_block;
  fcbm_pkg::name_t   res_name;
  logic              res_last;

  logic              name_we;
  logic [EW-1:0]     name_waddr;
  fcbm_pkg::name_t   name_rdata;
  logic              lk_we;
  fcbm_pkg::block_t  lk_waddr;
  fcbm_pkg::block_t  lk_wdata;
  fcbm_pkg::block_t  lk_raddr;
  fcbm_pkg::block_t  lk_rdata;

  logic [EW-1:0]     e_idx;
  logic              free_found;
  logic [EW-1:0]     free_idx;
  logic              nu_found;
  logic [CW-1:0]     nu_idx;
  fcbm_pkg::block_t  fmt_val;
  logic [8:0]        fmt_n;
  logic [8:0]        fmt_d;
  logic              out_free;

  assign e_idx = idx_q[EW-1:0];
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // lowest free entry, and next used entry after the current one (the first used one in S_LST)
  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    nu_found = 1'b0;
    nu_idx = '0;
    for (int i = ROOT_ENTRIES - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx = EW'(i);
      end
      if (used_q[i] && (state == S_LST || i > int'(idx_q))) begin
        nu_found = 1'b1;
        nu_idx = CW'(i);
      end
    end
  end

  // link value laid down by the format sweep
  always_comb begin
    fmt_n = (block_count > 9'd256) ? 9'd256 : block_count;
    fmt_d = (first_data_block < 8'd2) ? 9'd2 : {1'b0, first_data_block};
    if (steps == 9'd0) begin
      fmt_val = (fmt_d < fmt_n) ? fmt_d[7:0] : 8'd0;
    end else if (steps < fmt_d && steps < fmt_n) begin
      fmt_val = 8'd1;
    end else if (steps >= fmt_d && (steps + 9'd1) < fmt_n) begin
      fmt_val = steps[7:0] + 8'd1;
    end else begin
      fmt_val = 8'd0;
    end
  end

  always_comb begin
    name_we = (state == S_DISP) && (op_q == fcbm_pkg::OP_CREATE) && !found_q && free_found;
    name_waddr = free_idx;
    lk_we = 1'b0;
    lk_waddr = b_q;
    lk_wdata = alloc_q;
    lk_raddr = b_q;
    unique case (state)
      S_FMT: begin
        lk_we = 1'b1;
        lk_waddr = steps[7:0];
        lk_wdata = fmt_val;
      end
      S_AP0: lk_raddr = 8'd0;
      S_AP1: lk_raddr = lk_rdata;
      S_AP2: begin
        lk_we = 1'b1;
        lk_waddr = 8'd0;
        lk_wdata = lk_rdata;
      end
      S_AP3: begin
        lk_we = 1'b1;
        lk_waddr = alloc_q;
        lk_wdata = 8'd0;
      end
      S_AFIN: lk_we = 1'b1;
      S_UL2: lk_raddr = 8'd0;
      S_UL3: begin
        lk_we = (first_q[e_idx] != blk_q);
        lk_waddr = pred_q;
        lk_wdata = tmp_q;
      end
      S_UL4: begin
        lk_we = 1'b1;
        lk_waddr = blk_q;
        lk_wdata = alloc_q;
      end
      S_UL5: begin
        lk_we = 1'b1;
        lk_waddr = 8'd0;
        lk_wdata = blk_q;
      end
      default: lk_raddr = b_q;
    endcase
  end

  fcbm_ram #(.WIDTH(64), .DEPTH(NDEPTH)) u_names (
    .clk   (clk),
    .we    (name_we),
    .waddr (name_waddr),
    .wdata (name_q),
    .raddr (e_idx),
    .rdata (name_rdata)
  );

  fcbm_ram #(.WIDTH(fcbm_pkg::BLOCK_W), .DEPTH(fcbm_pkg::LINK_DEPTH)) u_links (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      steps <= '0;
      used_q <= '0;
      for (int i = 0; i < ROOT_ENTRIES; i++) begin
        first_q[i] <= 8'd0;
      end
      block_count <= 9'd256;
      first_data_block <= 8'd13;
    end else begin
      if (cfg_we) begin
        if (cfg_index == fcbm_pkg::CFG_BLOCK_COUNT) begin
          block_count <= cfg_data;
        end else begin
          first_data_block <= cfg_data[7:0];
        end
      end
      // the emit state loads the next result itself
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q <= op;
            name_q <= file_name;
            blk_q <= block_number;
            idx_q <= '0;
            steps <= '0;
            res_status <= fcbm_pkg::ST_NOT_FOUND;
            res_block <= 8'd0;
            res_name <= '0;
            res_last <= 1'b1;
            if (op == fcbm_pkg::OP_FORMAT) begin
              used_q <= '0;
              for (int i = 0; i < ROOT_ENTRIES; i++) begin
                first_q[i] <= 8'd0;
              end
              state <= S_FMT;
            end else if (op == fcbm_pkg::OP_LIST) begin
              state <= S_LST;
            end else if (op > fcbm_pkg::OP_LIST) begin
              state <= S_EMIT;
            end else begin
              state <= S_SRD;
            end
          end
        end
        S_FMT: begin
          steps <= steps + 9'd1;
          if (steps[7:0] == 8'hff) begin
            res_status <= fcbm_pkg::ST_OK;
            state <= S_EMIT;
          end
        end
        S_SRD: begin
          if (idx_q == CW'(ROOT_ENTRIES)) begin
            found_q <= 1'b0;
            state <= S_DISP;
          end else begin
            state <= S_SCMP;
          end
        end
        S_SCMP: begin
          if (used_q[e_idx] && name_rdata == name_q) begin
            found_q <= 1'b1;
            state <= S_DISP;
          end else begin
            idx_q <= idx_q + CW'(1);
            state <= S_SRD;
          end
        end
        S_DISP: begin
          state <= S_EMIT;
          b_q <= first_q[e_idx];
          if (op_q == fcbm_pkg::OP_CREATE) begin
            if (found_q) begin
              res_status <= fcbm_pkg::ST_EXISTS;
            end else if (free_found) begin
              used_q[free_idx] <= 1'b1;
              first_q[free_idx] <= 8'd0;
              res_status <= fcbm_pkg::ST_OK;
            end else begin
              res_status <= fcbm_pkg::ST_DIR_FULL;
            end
          end else if (found_q) begin
            priority case (op_q)
              fcbm_pkg::OP_REMOVE: begin
                if (first_q[e_idx] != 8'd0) begin
                  res_status <= fcbm_pkg::ST_NOT_EMPTY;
                end else begin
                  used_q[e_idx] <= 1'b0;
                  res_status <= fcbm_pkg::ST_OK;
                end
              end
              fcbm_pkg::OP_FIRST: begin
                res_status <= fcbm_pkg::ST_OK;
                res_block <= first_q[e_idx];
              end
              fcbm_pkg::OP_APPEND: state <= S_AP0;
              default: state <= S_MWI;
            endcase
          end
        end
        S_AP0: state <= S_AP1;
        S_AP1: begin
          alloc_q <= lk_rdata;
          if (lk_rdata == 8'd0) begin
            res_status <= fcbm_pkg::ST_DISK_FULL;
            state <= S_EMIT;
          end else begin
            state <= S_AP2;
          end
        end
        S_AP2: state <= S_AP3;
        S_AP3: begin
          if (first_q[e_idx] == 8'd0) begin
            first_q[e_idx] <= alloc_q;
            res_status <= fcbm_pkg::ST_OK;
            res_block <= alloc_q;
            state <= S_EMIT;
          end else begin
            state <= S_AWI;
          end
        end
        S_AWI: begin
          if (steps == fcbm_pkg::WALK_LIMIT) begin
            state <= S_AFIN;
          end else begin
            steps <= steps + 9'd1;
            state <= S_AWW;
          end
        end
        S_AWW: begin
          if (lk_rdata == 8'd0) begin
            state <= S_AFIN;
          end else begin
            b_q <= lk_rdata;
            state <= S_AWI;
          end
        end
        S_AFIN: begin
          res_status <= fcbm_pkg::ST_OK;
          res_block <= alloc_q;
          state <= S_EMIT;
        end
        // membership walk; the read of the current block is issued here
        S_MWI: begin
          if (steps == fcbm_pkg::WALK_LIMIT || b_q == 8'd0) begin
            res_status <= fcbm_pkg::ST_NOT_IN_CHAIN;
            state <= S_EMIT;
          end else if (b_q == blk_q) begin
            priority case (op_q)
              fcbm_pkg::OP_CHECK: begin
                res_status <= fcbm_pkg::ST_OK;
                state <= S_EMIT;
              end
              fcbm_pkg::OP_NEXT: state <= S_NX;
              default: state <= S_UL2;
            endcase
          end else begin
            steps <= steps + 9'd1;
            state <= S_MWW;
          end
        end
        S_MWW: begin
          pred_q <= b_q;
          b_q <= lk_rdata;
          state <= S_MWI;
        end
        S_NX: begin
          res_status <= fcbm_pkg::ST_OK;
          res_block <= lk_rdata;
          state <= S_EMIT;
        end
        S_UL2: begin
          tmp_q <= lk_rdata;
          state <= S_UL3;
        end
        S_UL3: begin
          alloc_q <= lk_rdata;
          if (first_q[e_idx] == blk_q) begin
            first_q[e_idx] <= tmp_q;
          end
          state <= S_UL4;
        end
        S_UL4: state <= S_UL5;
        S_UL5: begin
          res_status <= fcbm_pkg::ST_OK;
          state <= S_EMIT;
        end
        S_LST: begin
          if (nu_found) begin
            idx_q <= nu_idx;
            state <= S_LRD;
          end else begin
            state <= S_EMIT;
          end
        end
        S_LRD: state <= S_LGOT;
        S_LGOT: begin
          res_status <= fcbm_pkg::ST_OK;
          res_block <= first_q[e_idx];
          res_name <= name_rdata;
          res_last <= !nu_found || steps == 9'(fcbm_pkg::MAX_OUT - 1);
          steps <= steps + 9'd1;
          idx_q <= nu_idx;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            status <= res_status;
            result_block <= res_block;
            listed_name <= res_name;
            last <= res_last;
            state <= res_last ? S_IDLE : S_LRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != S_IDLE)
    else $error("accepted command did not start");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    steps <= fcbm_pkg::WALK_LIMIT)
    else $error("walk step count beyond limit");
  a_fmt_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_FMT |-> used_q == '0)
    else $error("directory not empty during format");
  a_emit_nonlast: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && out_free && !res_last |-> op_q == fcbm_pkg::OP_LIST)
    else $error("several results for a single-result command");
`endif

endmodule

### design/fcbm_ram.sv
// generic single write port ram with registered read
module fcbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
